FILE: rtl/core/drt_pkg.sv
// drt_pkg: shared types and constants of the device record table
// record layout, request kinds and the probe control bundle passed between cells
// no dependencies

package drt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int SELECT_W    = 5;
   localparam int INDEX_OUT_W = 5;
   localparam int COUNT_OUT_W = 6;

   typedef enum logic [1:0] {
      REQ_INSERT     = 2'd0,
      REQ_FIND_CLASS = 2'd1,
      REQ_FIND_ID    = 2'd2,
      REQ_GET        = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [7:0]  bus;
      logic [4:0]  dev;
      logic [2:0]  fn;
      logic [15:0] ven;
      logic [15:0] prod;
      logic [7:0]  cls;
      logic [7:0]  sub;
   } record_type;

   typedef struct packed {
      logic         active;
      logic         search;
      req_kind_type kind;
      logic         found;
   } probe_ctl_type;

endpackage

FILE: rtl/core/drt_cell.sv
// drt_cell: one table slot holding a single record
// compares the passing probe against its record and hands the probe on registered
// depends on drt_pkg

module drt_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 5,
   parameter int TGT_W      = 5,
   parameter int CNT_W      = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   input  logic [IDX_W-1:0]       wr_target,
   input  drt_pkg::record_type    wr_rec,
   input  logic [CNT_W-1:0]       fill_count,
   input  drt_pkg::probe_ctl_type in_ctl,
   input  drt_pkg::record_type    in_key,
   input  logic [TGT_W-1:0]       in_target,
   input  logic [IDX_W-1:0]       in_idx,
   input  drt_pkg::record_type    in_rec,
   output drt_pkg::probe_ctl_type out_ctl,
   output drt_pkg::record_type    out_key,
   output logic [TGT_W-1:0]       out_target,
   output logic [IDX_W-1:0]       out_idx,
   output drt_pkg::record_type    out_rec
);

   drt_pkg::record_type    rec_ff;
   drt_pkg::probe_ctl_type ctl_ff;
   drt_pkg::probe_ctl_type ctl_in;
   drt_pkg::record_type    key_ff;
   logic [TGT_W-1:0]       target_ff;
   logic [IDX_W-1:0]       idx_ff;
   drt_pkg::record_type    res_ff;
   logic                   occupied;
   logic                   match;
   logic                   take;

   assign occupied = CNT_W'(CELL_INDEX) < fill_count;

   always_comb begin
      unique case (in_ctl.kind)
         drt_pkg::REQ_INSERT,
         drt_pkg::REQ_GET: begin
            match = in_target == TGT_W'(CELL_INDEX);
         end
         drt_pkg::REQ_FIND_CLASS: begin
            match = (rec_ff.cls == in_key.cls) && (rec_ff.sub == in_key.sub);
         end
         drt_pkg::REQ_FIND_ID: begin
            match = (rec_ff.ven == in_key.ven) && (rec_ff.prod == in_key.prod);
         end
         default: begin
            match = 1'b0;
         end
      endcase
   end

   assign take = in_ctl.active && in_ctl.search && !in_ctl.found && occupied && match;

   always_comb begin
      ctl_in       = in_ctl;
      ctl_in.found = in_ctl.found || take;
   end

   always_ff @(posedge clock) begin
      if (wr_valid && (wr_target == IDX_W'(CELL_INDEX))) begin
         rec_ff <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= in_key;
      target_ff <= in_target;
      idx_ff    <= take ? IDX_W'(CELL_INDEX) : in_idx;
      res_ff    <= take ? rec_ff : in_rec;
   end

   assign out_ctl    = ctl_ff;
   assign out_key    = key_ff;
   assign out_target = target_ff;
   assign out_idx    = idx_ff;
   assign out_rec    = res_ff;

endmodule

FILE: rtl/core/device_record_table_unit.sv
// device_record_table_unit: top level of the device record table
// a row of drt_cell slots walked by a registered probe; depends on drt_pkg and drt_cell
//
// A request is taken when start is high and busy is low; busy then stays high until the
// result has been shown. The probe moves through one slot per clock, so the result strobe
// rsp_valid rises once the probe has passed the head register, every slot and the result
// register, and lasts one cycle; the next request can be taken once busy has dropped after
// the strobe. The strobe cannot be held off. Inserts are written at the accepting edge, and
// the count reported with each result is the count after that request.

module device_record_table_unit #(
   parameter int TABLE_DEPTH = drt_pkg::TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_type,
   input  logic [7:0]                       req_bus_number,
   input  logic [4:0]                       req_device_number,
   input  logic [2:0]                       req_function_number,
   input  logic [15:0]                      req_vendor_key,
   input  logic [15:0]                      req_product_key,
   input  logic [7:0]                       req_class_key,
   input  logic [7:0]                       req_subclass_key,
   input  logic [drt_pkg::SELECT_W-1:0]     req_entry_select,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [drt_pkg::INDEX_OUT_W-1:0]  rsp_entry_index,
   output logic [7:0]                       rsp_entry_bus,
   output logic [4:0]                       rsp_entry_device,
   output logic [2:0]                       rsp_entry_function,
   output logic [15:0]                      rsp_entry_vendor,
   output logic [15:0]                      rsp_entry_product,
   output logic [7:0]                       rsp_entry_class,
   output logic [7:0]                       rsp_entry_subclass,
   output logic [drt_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TGT_W = (IDX_W > drt_pkg::SELECT_W) ? IDX_W : drt_pkg::SELECT_W;

   logic                   busy_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   accept;
   logic                   full;
   drt_pkg::req_kind_type  kind;
   drt_pkg::record_type    req_rec;
   logic                   wr_valid;

   drt_pkg::probe_ctl_type head_ctl_ff;
   drt_pkg::probe_ctl_type head_ctl_in;
   drt_pkg::record_type    head_key_ff;
   logic [TGT_W-1:0]       head_target_ff;
   logic [TGT_W-1:0]       head_target_in;

   drt_pkg::probe_ctl_type ctl_chain    [0:TABLE_DEPTH];
   drt_pkg::record_type    key_chain    [0:TABLE_DEPTH];
   logic [TGT_W-1:0]       target_chain [0:TABLE_DEPTH];
   logic [IDX_W-1:0]       idx_chain    [0:TABLE_DEPTH];
   drt_pkg::record_type    rec_chain    [0:TABLE_DEPTH];

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [drt_pkg::INDEX_OUT_W-1:0] rsp_index_ff;
   drt_pkg::record_type    rsp_rec_ff;
   logic [IDX_W+drt_pkg::INDEX_OUT_W-1:0] idx_wide;
   logic [CNT_W+drt_pkg::COUNT_OUT_W-1:0] count_wide;

   assign accept = start && !busy_ff;
   assign kind   = drt_pkg::req_kind_type'(req_type);
   assign full   = count_ff == CNT_W'(TABLE_DEPTH);

   assign req_rec.bus  = req_bus_number;
   assign req_rec.dev  = req_device_number;
   assign req_rec.fn   = req_function_number;
   assign req_rec.ven  = req_vendor_key;
   assign req_rec.prod = req_product_key;
   assign req_rec.cls  = req_class_key;
   assign req_rec.sub  = req_subclass_key;

   assign wr_valid = accept && (kind == drt_pkg::REQ_INSERT) && !full;

   always_comb begin
      head_ctl_in.active = accept;
      head_ctl_in.search = !((kind == drt_pkg::REQ_INSERT) && full);
      head_ctl_in.kind   = kind;
      head_ctl_in.found  = 1'b0;
      head_target_in     = (kind == drt_pkg::REQ_GET) ? TGT_W'(req_entry_select)
                                                      : TGT_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         count_ff    <= '0;
         head_ctl_ff <= '0;
      end else begin
         head_ctl_ff <= head_ctl_in;
         if (wr_valid) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         priority if (accept) begin
            busy_ff <= 1'b1;
         end else if (rsp_valid_ff) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_key_ff    <= req_rec;
      head_target_ff <= head_target_in;
   end

   assign ctl_chain[0]    = head_ctl_ff;
   assign key_chain[0]    = head_key_ff;
   assign target_chain[0] = head_target_ff;
   assign idx_chain[0]    = '0;
   assign rec_chain[0]    = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      drt_cell #(
         .CELL_INDEX (g),
         .IDX_W      (IDX_W),
         .TGT_W      (TGT_W),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_valid   (wr_valid),
         .wr_target  (IDX_W'(count_ff)),
         .wr_rec     (req_rec),
         .fill_count (count_ff),
         .in_ctl     (ctl_chain[g]),
         .in_key     (key_chain[g]),
         .in_target  (target_chain[g]),
         .in_idx     (idx_chain[g]),
         .in_rec     (rec_chain[g]),
         .out_ctl    (ctl_chain[g+1]),
         .out_key    (key_chain[g+1]),
         .out_target (target_chain[g+1]),
         .out_idx    (idx_chain[g+1]),
         .out_rec    (rec_chain[g+1])
      );
   end

   assign idx_wide   = (IDX_W + drt_pkg::INDEX_OUT_W)'(idx_chain[TABLE_DEPTH]);
   assign count_wide = (CNT_W + drt_pkg::COUNT_OUT_W)'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_chain[TABLE_DEPTH].active;
      end
   end

   // miss results carry zero entry fields
   always_ff @(posedge clock) begin
      rsp_hit_ff <= ctl_chain[TABLE_DEPTH].found;
      if (ctl_chain[TABLE_DEPTH].found) begin
         rsp_index_ff <= idx_wide[drt_pkg::INDEX_OUT_W-1:0];
         rsp_rec_ff   <= rec_chain[TABLE_DEPTH];
      end else begin
         rsp_index_ff <= '0;
         rsp_rec_ff   <= '0;
      end
   end

   assign busy               = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_entry_index    = rsp_index_ff;
   assign rsp_entry_bus      = rsp_rec_ff.bus;
   assign rsp_entry_device   = rsp_rec_ff.dev;
   assign rsp_entry_function = rsp_rec_ff.fn;
   assign rsp_entry_vendor   = rsp_rec_ff.ven;
   assign rsp_entry_product  = rsp_rec_ff.prod;
   assign rsp_entry_class    = rsp_rec_ff.cls;
   assign rsp_entry_subclass = rsp_rec_ff.sub;
   assign rsp_entry_count    = count_wide[drt_pkg::COUNT_OUT_W-1:0];

endmodule

FILE: rtl/core/drt_checker.sv
// drt_checker: port-level assertions for device_record_table_unit
// attached to the top level by the bind statement at the end; depends on drt_pkg

module drt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_hit,
   input logic [drt_pkg::INDEX_OUT_W-1:0]  rsp_entry_index,
   input logic [7:0]                       rsp_entry_bus,
   input logic [4:0]                       rsp_entry_device,
   input logic [2:0]                       rsp_entry_function,
   input logic [15:0]                      rsp_entry_vendor,
   input logic [15:0]                      rsp_entry_product,
   input logic [7:0]                       rsp_entry_class,
   input logic [7:0]                       rsp_entry_subclass
);

   // a strobe only shows for a request in flight
   a_strobe_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe without a request in flight");

   // the result frees the block
   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block still busy after its result");

   // an accepted request holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted request did not raise busy");

   // miss results carry zero entry fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_entry_index == '0 && rsp_entry_bus == '0 &&
         rsp_entry_device == '0 && rsp_entry_function == '0 &&
         rsp_entry_vendor == '0 && rsp_entry_product == '0 &&
         rsp_entry_class == '0 && rsp_entry_subclass == '0)
      else $error("miss result with nonzero entry fields");

endmodule

bind device_record_table_unit drt_checker u_drt_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_hit            (rsp_hit),
   .rsp_entry_index    (rsp_entry_index),
   .rsp_entry_bus      (rsp_entry_bus),
   .rsp_entry_device   (rsp_entry_device),
   .rsp_entry_function (rsp_entry_function),
   .rsp_entry_vendor   (rsp_entry_vendor),
   .rsp_entry_product  (rsp_entry_product),
   .rsp_entry_class    (rsp_entry_class),
   .rsp_entry_subclass (rsp_entry_subclass)
);

FILE: tb/device_record_table_checker.sv
`timescale 1ns / 100ps
// device_record_table_checker: watches the request and response ports of the table,
// keeps its own copy of the stored records and compares every response field by field
// depends on drt_pkg

module device_record_table_checker #(
   parameter int DEPTH = drt_pkg::TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [1:0]                       req_type,
   input  logic [7:0]                       req_bus_number,
   input  logic [4:0]                       req_device_number,
   input  logic [2:0]                       req_function_number,
   input  logic [15:0]                      req_vendor_key,
   input  logic [15:0]                      req_product_key,
   input  logic [7:0]                       req_class_key,
   input  logic [7:0]                       req_subclass_key,
   input  logic [drt_pkg::SELECT_W-1:0]     req_entry_select,
   input  logic                             rsp_valid,
   input  logic                             rsp_hit,
   input  logic [drt_pkg::INDEX_OUT_W-1:0]  rsp_entry_index,
   input  logic [7:0]                       rsp_entry_bus,
   input  logic [4:0]                       rsp_entry_device,
   input  logic [2:0]                       rsp_entry_function,
   input  logic [15:0]                      rsp_entry_vendor,
   input  logic [15:0]                      rsp_entry_product,
   input  logic [7:0]                       rsp_entry_class,
   input  logic [7:0]                       rsp_entry_subclass,
   input  logic [drt_pkg::COUNT_OUT_W-1:0]  rsp_entry_count,
   output int                               fail_count,
   output int                               open_count,
   output int                               checked_count,
   output int                               hit_count
);

   typedef struct packed {
      logic                            hit;
      logic [drt_pkg::INDEX_OUT_W-1:0] index;
      drt_pkg::record_type             rec;
      logic [drt_pkg::COUNT_OUT_W-1:0] count;
   } table_response_type;

   drt_pkg::record_type stored_records [DEPTH];
   int                  stored_count = 0;
   table_response_type  pending_responses [$];
   int                  errors = 0;
   int                  checked = 0;
   int                  hits = 0;

   function automatic table_response_type predict_response(
         input drt_pkg::req_kind_type kind, input drt_pkg::record_type key,
         input logic [drt_pkg::SELECT_W-1:0] sel);
      table_response_type resp;
      resp = '0;
      case (kind)
         drt_pkg::REQ_INSERT: begin
            if (stored_count < DEPTH) begin
               stored_records[stored_count] = key;
               resp.hit   = 1'b1;
               resp.index = (drt_pkg::INDEX_OUT_W)'(stored_count);
               resp.rec   = key;
               stored_count++;
            end
         end
         drt_pkg::REQ_GET: begin
            if (int'(sel) < stored_count) begin
               resp.hit   = 1'b1;
               resp.index = (drt_pkg::INDEX_OUT_W)'(sel);
               resp.rec   = stored_records[sel];
            end
         end
         default: begin
            for (int i = 0; i < stored_count; i++) begin
               if (!resp.hit && ((kind == drt_pkg::REQ_FIND_CLASS) ?
                     (stored_records[i].cls == key.cls && stored_records[i].sub == key.sub) :
                     (stored_records[i].ven == key.ven && stored_records[i].prod == key.prod)))
               begin
                  resp.hit   = 1'b1;
                  resp.index = (drt_pkg::INDEX_OUT_W)'(i);
                  resp.rec   = stored_records[i];
               end
            end
         end
      endcase
      resp.count = (drt_pkg::COUNT_OUT_W)'(stored_count);
      return resp;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      table_response_type  want;
      drt_pkg::record_type key;
      if (reset) begin
         stored_count = 0;
         pending_responses.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_responses.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, got hit %b",
                  $time, rsp_hit);
               errors++;
            end else begin
               want = pending_responses.pop_front();
               checked++;
               if (want.hit) hits++;
               check_field("hit", 16'(want.hit), 16'(rsp_hit));
               check_field("entry_index", 16'(want.index), 16'(rsp_entry_index));
               check_field("entry_bus", 16'(want.rec.bus), 16'(rsp_entry_bus));
               check_field("entry_device", 16'(want.rec.dev), 16'(rsp_entry_device));
               check_field("entry_function", 16'(want.rec.fn), 16'(rsp_entry_function));
               check_field("entry_vendor", want.rec.ven, rsp_entry_vendor);
               check_field("entry_product", want.rec.prod, rsp_entry_product);
               check_field("entry_class", 16'(want.rec.cls), 16'(rsp_entry_class));
               check_field("entry_subclass", 16'(want.rec.sub), 16'(rsp_entry_subclass));
               check_field("entry_count", 16'(want.count), 16'(rsp_entry_count));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            key.bus  = req_bus_number;
            key.dev  = req_device_number;
            key.fn   = req_function_number;
            key.ven  = req_vendor_key;
            key.prod = req_product_key;
            key.cls  = req_class_key;
            key.sub  = req_subclass_key;
            pending_responses.push_back(
               predict_response(drt_pkg::req_kind_type'(req_type), key, req_entry_select));
         end
      end
      fail_count    <= errors;
      open_count    <= pending_responses.size();
      checked_count <= checked;
      hit_count     <= hits;
   end

endmodule

FILE: tb/tb_device_record_table_unit.sv
`timescale 1ns / 100ps
// tb_device_record_table_unit: drives directed and random table requests in bursts
// and reports the verdict; depends on drt_pkg, device_record_table_unit and
// device_record_table_checker

module tb_device_record_table_unit;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [1:0]                      req_type = drt_pkg::REQ_INSERT;
   logic [7:0]                      req_bus_number = '0;
   logic [4:0]                      req_device_number = '0;
   logic [2:0]                      req_function_number = '0;
   logic [15:0]                     req_vendor_key = '0;
   logic [15:0]                     req_product_key = '0;
   logic [7:0]                      req_class_key = '0;
   logic [7:0]                      req_subclass_key = '0;
   logic [drt_pkg::SELECT_W-1:0]    req_entry_select = '0;
   logic                            rsp_valid;
   logic                            rsp_hit;
   logic [drt_pkg::INDEX_OUT_W-1:0] rsp_entry_index;
   logic [7:0]                      rsp_entry_bus;
   logic [4:0]                      rsp_entry_device;
   logic [2:0]                      rsp_entry_function;
   logic [15:0]                     rsp_entry_vendor;
   logic [15:0]                     rsp_entry_product;
   logic [7:0]                      rsp_entry_class;
   logic [7:0]                      rsp_entry_subclass;
   logic [drt_pkg::COUNT_OUT_W-1:0] rsp_entry_count;

   int fail_count;
   int open_count;
   int checked_count;
   int hit_count;
   int kind_sent [4] = '{default: 0};

   logic [7:0]  class_pool    [4];
   logic [7:0]  subclass_pool [4];
   logic [15:0] vendor_pool   [4];
   logic [15:0] product_pool  [4];

   device_record_table_unit u_top (.*);

   device_record_table_checker u_checker (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_request(input drt_pkg::req_kind_type kind, input logic [7:0] bus,
         input logic [4:0] dev, input logic [2:0] fn, input logic [15:0] ven,
         input logic [15:0] prod, input logic [7:0] cls, input logic [7:0] sub,
         input logic [drt_pkg::SELECT_W-1:0] sel);
      req_type            <= kind;
      req_bus_number      <= bus;
      req_device_number   <= dev;
      req_function_number <= fn;
      req_vendor_key      <= ven;
      req_product_key     <= prod;
      req_class_key       <= cls;
      req_subclass_key    <= sub;
      req_entry_select    <= sel;
      start               <= 1'b1;
      kind_sent[kind]++;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // mostly lookups on a small key pool so that matches and ties are common
   task automatic random_request();
      int                    roll;
      int                    p;
      int                    q;
      drt_pkg::req_kind_type kind;
      logic [7:0]            cls;
      logic [7:0]            sub;
      logic [15:0]           ven;
      logic [15:0]           prod;
      roll = $urandom_range(0, 99);
      if (roll < 6) kind = drt_pkg::REQ_INSERT;
      else if (roll < 40) kind = drt_pkg::REQ_FIND_CLASS;
      else if (roll < 75) kind = drt_pkg::REQ_FIND_ID;
      else kind = drt_pkg::REQ_GET;
      p = $urandom_range(0, 3);
      q = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : p;
      if ($urandom_range(0, 9) < 7) begin
         cls  = class_pool[p];
         sub  = subclass_pool[q];
         ven  = vendor_pool[p];
         prod = product_pool[q];
      end else begin
         cls  = 8'($urandom);
         sub  = 8'($urandom);
         ven  = 16'($urandom);
         prod = 16'($urandom);
      end
      send_request(kind, 8'($urandom), 5'($urandom), 3'($urandom), ven, prod, cls, sub,
         (drt_pkg::SELECT_W)'($urandom));
   endtask

   initial begin
      int sent;
      int burst;
      for (int i = 0; i < 4; i++) begin
         class_pool[i]    = 8'($urandom);
         subclass_pool[i] = 8'($urandom);
         vendor_pool[i]   = 16'($urandom);
         product_pool[i]  = 16'($urandom);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // empty table
      send_request(drt_pkg::REQ_FIND_CLASS, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00,
         8'h00, 5'h00);
      send_request(drt_pkg::REQ_FIND_ID, 8'hff, 5'h1f, 3'h7, 16'hffff, 16'hffff, 8'hff,
         8'hff, 5'h1f);
      send_request(drt_pkg::REQ_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00,
         8'h00, 5'h00);
      send_request(drt_pkg::REQ_GET, 8'hff, 5'h1f, 3'h7, 16'hffff, 16'hffff, 8'hff,
         8'hff, 5'h1f);
      // inserts, with a duplicate of the all-ones keys
      send_request(drt_pkg::REQ_INSERT, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00,
         8'h00, 5'h00);
      send_request(drt_pkg::REQ_INSERT, 8'hff, 5'h1f, 3'h7, 16'hffff, 16'hffff, 8'hff,
         8'hff, 5'h1f);
      send_request(drt_pkg::REQ_INSERT, 8'h5a, 5'h0a, 3'h5, 16'hffff, 16'hffff, 8'hff,
         8'hff, 5'h00);
      send_request(drt_pkg::REQ_INSERT, 8'ha5, 5'h15, 3'h2, 16'h8086, 16'h1234, 8'h02,
         8'h00, 5'h00);
      // lowest index wins on ties
      send_request(drt_pkg::REQ_FIND_CLASS, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'hff,
         8'hff, 5'h00);
      send_request(drt_pkg::REQ_FIND_ID, 8'h00, 5'h00, 3'h0, 16'hffff, 16'hffff, 8'h00,
         8'h00, 5'h00);
      send_request(drt_pkg::REQ_FIND_CLASS, 8'hff, 5'h1f, 3'h7, 16'hffff, 16'hffff, 8'h00,
         8'h00, 5'h1f);
      send_request(drt_pkg::REQ_FIND_ID, 8'hff, 5'h1f, 3'h7, 16'h0000, 16'h0000, 8'hff,
         8'hff, 5'h1f);
      // partial key matches miss, a full key match hits
      send_request(drt_pkg::REQ_FIND_CLASS, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h02,
         8'hff, 5'h00);
      send_request(drt_pkg::REQ_FIND_ID, 8'h00, 5'h00, 3'h0, 16'h8086, 16'h0000, 8'h00,
         8'h00, 5'h00);
      send_request(drt_pkg::REQ_FIND_ID, 8'h00, 5'h00, 3'h0, 16'h8086, 16'h1234, 8'h00,
         8'h00, 5'h00);
      // get below and at the count
      send_request(drt_pkg::REQ_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00,
         8'h00, 5'h03);
      send_request(drt_pkg::REQ_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00,
         8'h00, 5'h04);
      send_request(drt_pkg::REQ_GET, 8'h00, 5'h00, 3'h0, 16'h0000, 16'h0000, 8'h00,
         8'h00, 5'h02);
      start <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);

      sent = 0;
      while (sent < 2000) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
         repeat (burst) begin
            random_request();
            sent++;
         end
         start <= 1'b0;
         @(posedge clock);
         if ($urandom_range(0, 49) == 0) begin
            while (open_count != 0) @(posedge clock);
         end else begin
            repeat ($urandom_range(0, 44)) @(posedge clock);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (drt_pkg::TABLE_DEPTH + 8) @(posedge clock);
      $display("requests sent: %0d insert, %0d find by class, %0d find by id, %0d get",
         kind_sent[drt_pkg::REQ_INSERT], kind_sent[drt_pkg::REQ_FIND_CLASS],
         kind_sent[drt_pkg::REQ_FIND_ID], kind_sent[drt_pkg::REQ_GET]);
      $display("responses checked: %0d, of which %0d hit", checked_count, hit_count);
      if (fail_count == 0 && open_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
